// ===== design/shell_command_lexer_core_macros.svh =====
// Assertion macros shared by the lexer RTL
`ifndef SHELL_COMMAND_LEXER_CORE_MACROS_SVH
`define SHELL_COMMAND_LEXER_CORE_MACROS_SVH

// Holds on every clock edge outside reset
`define SCL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/scl_pkg.sv =====
// Types, character codes and record helpers for the shell command lexer
package scl_pkg;

	localparam int unsigned POS_W = 13;

	typedef enum logic [2:0] {
		KIND_STR_BYTE = 3'd0,
		KIND_STR_END  = 3'd1,
		KIND_PIPE     = 3'd2,
		KIND_AMP      = 3'd3,
		KIND_SEMI     = 3'd4,
		KIND_EOI      = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		QUOTE_NONE   = 2'd0,
		QUOTE_SINGLE = 2'd1,
		QUOTE_DOUBLE = 2'd2
	} quote_t;

	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef struct packed {
		logic             last;
		logic             quote_open;
		logic [POS_W-1:0] after_pos;
		logic [POS_W-1:0] first_pos;
		logic [7:0]       content_byte;
		kind_t            kind;
	} rec_t;

	function automatic rec_t mk_rec(kind_t k, logic [7:0] b, logic [POS_W-1:0] f,
			logic [POS_W-1:0] a, logic q);
		rec_t r;
		r.last         = 1'b0;
		r.quote_open   = q;
		r.after_pos    = a;
		r.first_pos    = f;
		r.content_byte = b;
		r.kind         = k;
		return r;
	endfunction

endpackage

// ===== design/shell_command_lexer_core.sv =====
// Shell command lexer: byte stream in, token records out
//
//  channel | dir | tdata                      | tlast
//  --------+-----+----------------------------+-----------------------
//  s_*     | in  | char_in                    | final_byte
//  m_*     | out | kind, content_byte,        | last_record
//          |     | first_pos, after_pos,      |
//          |     | quote_open                 |
//
// A byte is lexed in the cycle it is taken; its 0..3 records land in a
// 4-entry record queue whose head is the output register. A new byte is
// taken while at most one record is still waiting, so bytes that give at
// most one record stream at one per cycle while the output takes them; a
// byte with more records holds the input until at most one record is left.
// Reset (arst_n low) empties the queue and returns the lexer to the start of a command; no clearing pass is needed.
`include "shell_command_lexer_core_macros.svh"

module shell_command_lexer_core #(
	parameter int unsigned MAX_LEN = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [2:0] kind, [10:3] content_byte, [23:11] first_pos,
	                               // [36:24] after_pos, [37] quote_open, [39:38] zero
	output logic        m_tlast    // last_record
);
	import scl_pkg::*;

	localparam int unsigned PW   = $clog2(MAX_LEN + 1);
	localparam int unsigned PW_E = (PW > POS_W) ? PW : POS_W;
	localparam int unsigned QD   = 4;

	logic [PW_E-1:0] pos_q, tok_start_q;
	logic            inside_q;
	quote_t          quote_q;
	logic [7:0]      prev_q;

	rec_t            slot_q [QD];
	rec_t            slot_d [QD];
	logic [2:0]      cnt_q, cnt_d, cnt_base;

	logic            take, pop;
	rec_t            rec [3];
	logic [1:0]      n_rec;

	logic [PW_E-1:0] pos_d, tok_start_d, p1;
	logic            inside_d;
	quote_t          quote_d;
	logic [7:0]      c;
	logic            fin, is_sep, qclose;
	logic [POS_W-1:0] p_o, p1_o, ts_o;

	assign s_tready = (cnt_q <= 3'd1);
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = (cnt_q != 3'd0);
	assign pop      = m_tvalid && m_tready;

	assign c   = s_tdata;
	assign fin = s_tlast;
	// position saturates at MAX_LEN
	assign p1   = (pos_q >= PW_E'(MAX_LEN)) ? pos_q : pos_q + PW_E'(1);
	assign p_o  = pos_q[POS_W-1:0];
	assign p1_o = p1[POS_W-1:0];

	always_comb begin
		is_sep = c inside {CH_SPACE, CH_TAB, CH_LF, CH_NUL, CH_PIPE, CH_AMP, CH_SEMI};
		qclose = (prev_q != CH_BSLASH) &&
			(((quote_q == QUOTE_SINGLE) && (c == CH_SQUOTE)) ||
			 ((quote_q == QUOTE_DOUBLE) && (c == CH_DQUOTE)));
	end

	always_comb begin
		rec[0]      = '0;
		rec[1]      = '0;
		rec[2]      = '0;
		n_rec       = 2'd0;
		inside_d    = inside_q;
		quote_d     = quote_q;
		tok_start_d = tok_start_q;
		ts_o        = tok_start_q[POS_W-1:0];

		if (quote_q != QUOTE_NONE) begin
			if (qclose) begin
				quote_d = QUOTE_NONE;
			end else begin
				rec[n_rec] = mk_rec(KIND_STR_BYTE, c, p_o, p1_o, 1'b0);
				n_rec      = n_rec + 2'd1;
			end
		end else if (is_sep) begin
			if (inside_q) begin
				rec[n_rec] = mk_rec(KIND_STR_END, 8'h00, ts_o, p_o, 1'b0);
				n_rec      = n_rec + 2'd1;
				inside_d   = 1'b0;
			end
			case (c)
				CH_PIPE: begin
					rec[n_rec] = mk_rec(KIND_PIPE, 8'h00, p_o, p1_o, 1'b0);
					n_rec      = n_rec + 2'd1;
				end
				CH_AMP: begin
					rec[n_rec] = mk_rec(KIND_AMP, 8'h00, p_o, p1_o, 1'b0);
					n_rec      = n_rec + 2'd1;
				end
				CH_SEMI: begin
					rec[n_rec] = mk_rec(KIND_SEMI, 8'h00, p_o, p1_o, 1'b0);
					n_rec      = n_rec + 2'd1;
				end
				default: ;
			endcase
		end else begin
			if (!inside_q) begin
				inside_d    = 1'b1;
				tok_start_d = pos_q;
				ts_o        = p_o;
			end
			if (c == CH_SQUOTE) begin
				quote_d = QUOTE_SINGLE;
			end else if (c == CH_DQUOTE) begin
				quote_d = QUOTE_DOUBLE;
			end else begin
				rec[n_rec] = mk_rec(KIND_STR_BYTE, c, p_o, p1_o, 1'b0);
				n_rec      = n_rec + 2'd1;
			end
		end

		pos_d = p1;
		if (fin) begin
			// unterminated quote or open string closes at end of input
			if (inside_d) begin
				rec[n_rec] = mk_rec(KIND_STR_END, 8'h00, ts_o, p1_o, 1'b0);
				n_rec      = n_rec + 2'd1;
			end
			rec[n_rec]  = mk_rec(KIND_EOI, 8'h00, p1_o, p1_o, quote_d != QUOTE_NONE);
			n_rec       = n_rec + 2'd1;
			pos_d       = '0;
			inside_d    = 1'b0;
			quote_d     = QUOTE_NONE;
			tok_start_d = '0;
		end

		if (n_rec != 2'd0)
			rec[n_rec - 2'd1].last = 1'b1;
	end

	// record queue: shift out at the head, append behind the survivors
	always_comb begin
		slot_d   = slot_q;
		cnt_base = cnt_q;
		if (pop) begin
			for (int i = 0; i < QD - 1; i++)
				slot_d[i] = slot_q[i+1];
			cnt_base = cnt_q - 3'd1;
		end
		cnt_d = cnt_base;
		if (take) begin
			for (int k = 0; k < 3; k++)
				if (2'(k) < n_rec)
					slot_d[cnt_base[1:0] + 2'(k)] = rec[k];
			cnt_d = cnt_base + {1'b0, n_rec};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			tok_start_q <= '0;
			inside_q    <= 1'b0;
			quote_q     <= QUOTE_NONE;
			prev_q      <= 8'h00;
			cnt_q       <= 3'd0;
		end else begin
			cnt_q <= cnt_d;
			if (take) begin
				pos_q       <= pos_d;
				tok_start_q <= tok_start_d;
				inside_q    <= inside_d;
				quote_q     <= quote_d;
				prev_q      <= fin ? 8'h00 : c;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

	assign m_tdata = {2'b00, slot_q[0].quote_open, slot_q[0].after_pos,
		slot_q[0].first_pos, slot_q[0].content_byte, slot_q[0].kind};
	assign m_tlast = slot_q[0].last;

	`SCL_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= 3'(QD), "record queue overflow")
	`SCL_ASSERT_ALWAYS(a_quote_in_str, (quote_q == QUOTE_NONE) || inside_q,
		"quote open outside a string token")
	`SCL_ASSERT_ALWAYS(a_pos_sat, pos_q <= PW_E'(MAX_LEN), "position past saturation")
	`SCL_ASSERT_NEXT(a_fin_reset, take && fin,
		(pos_q == '0) && !inside_q && (quote_q == QUOTE_NONE),
		"lexer state not cleared after final byte")

endmodule

// ===== tb/shell_command_lexer_core_tb.sv =====
// Self-checking testbench for the shell command lexer core
module shell_command_lexer_core_tb;
	import scl_pkg::*;

	localparam int POS_LIMIT    = 4096;
	localparam int RESET_CYCLES = 6;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 24;
	localparam int STUCK_LIMIT  = 2000;
	localparam int PHASE_BYTES  = 38;

	typedef enum int {
		PH_DIRECTED,
		PH_STEADY,
		PH_SRC_IDLE,
		PH_SNK_STALL,
		PH_BOTH_IDLE,
		PH_BACKPRESSURE
	} phase_t;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
		phase_t     ph;
	} cmd_byte_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       content;
		logic [POS_W-1:0] first_pos;
		logic [POS_W-1:0] after_pos;
		logic             quote_open;
		logic             last;
	} token_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	cmd_byte_t  pending_bytes[$];
	cmd_byte_t  bus_byte;
	token_rec_t expected_recs[$];
	logic [7:0] cmd_buf[$];
	phase_t     cur_phase = PH_DIRECTED;

	// lexer state mirrored by the predictor
	int unsigned next_pos;
	logic        in_string;
	quote_t      open_quote;
	logic [7:0]  prev_ch;
	int unsigned tok_start;
	token_rec_t  byte_recs[3];
	int          byte_nrec;

	int  err_cnt;
	int  n_bytes;
	int  n_cmds;
	int  n_recs;
	int  hold_left;
	bit  held_once;

	shell_command_lexer_core #(.MAX_LEN(POS_LIMIT)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	task automatic emit(input kind_t k, input logic [7:0] b, input int unsigned f,
			input int unsigned a, input logic q);
		token_rec_t r;
		r.kind       = k;
		r.content    = b;
		r.first_pos  = f[POS_W-1:0];
		r.after_pos  = a[POS_W-1:0];
		r.quote_open = q;
		r.last       = 1'b0;
		byte_recs[byte_nrec] = r;
		byte_nrec++;
	endtask

	task automatic lex_byte(input logic [7:0] ch, input logic fin);
		int unsigned p;
		int unsigned p1;
		logic [7:0]  qc;
		token_rec_t  r;
		p  = next_pos;
		p1 = (p + 1 > POS_LIMIT) ? POS_LIMIT : p + 1;
		byte_nrec = 0;
		if (open_quote != QUOTE_NONE) begin
			qc = (open_quote == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
			if (ch == qc && prev_ch != CH_BSLASH)
				open_quote = QUOTE_NONE;
			else
				emit(KIND_STR_BYTE, ch, p, p1, 1'b0);
		end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_NUL ||
				ch == CH_PIPE || ch == CH_AMP || ch == CH_SEMI) begin
			if (in_string) begin
				emit(KIND_STR_END, 8'h00, tok_start, p, 1'b0);
				in_string = 1'b0;
			end
			case (ch)
				CH_PIPE: emit(KIND_PIPE, 8'h00, p, p1, 1'b0);
				CH_AMP:  emit(KIND_AMP, 8'h00, p, p1, 1'b0);
				CH_SEMI: emit(KIND_SEMI, 8'h00, p, p1, 1'b0);
				default: ;
			endcase
		end else begin
			if (!in_string) begin
				in_string = 1'b1;
				tok_start = p;
			end
			// quotes open a region even right after a backslash
			if (ch == CH_SQUOTE)
				open_quote = QUOTE_SINGLE;
			else if (ch == CH_DQUOTE)
				open_quote = QUOTE_DOUBLE;
			else
				emit(KIND_STR_BYTE, ch, p, p1, 1'b0);
		end
		prev_ch  = ch;
		next_pos = p1;
		if (fin) begin
			if (in_string)
				emit(KIND_STR_END, 8'h00, tok_start, p1, 1'b0);
			emit(KIND_EOI, 8'h00, p1, p1, open_quote != QUOTE_NONE);
			next_pos   = 0;
			in_string  = 1'b0;
			open_quote = QUOTE_NONE;
			prev_ch    = 8'h00;
			tok_start  = 0;
		end
		for (int i = 0; i < byte_nrec; i++) begin
			r = byte_recs[i];
			r.last = (i == byte_nrec - 1);
			expected_recs.insert(expected_recs.size(), r);
		end
	endtask

	task automatic push_byte(input logic [7:0] ch, input logic fin, input phase_t ph);
		cmd_byte_t it;
		it.ch  = ch;
		it.fin = fin;
		it.ph  = ph;
		pending_bytes.insert(pending_bytes.size(), it);
		if (fin)
			n_cmds++;
	endtask

	task automatic put_ch(input logic [7:0] b);
		cmd_buf.insert(cmd_buf.size(), b);
	endtask

	// plain word byte: no separator, no quote
	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(8'h21, 8'hFF));
		while (b == CH_PIPE || b == CH_AMP || b == CH_SEMI || b == CH_SQUOTE ||
			b == CH_DQUOTE);
		return b;
	endfunction

	task automatic add_command(input phase_t ph);
		logic [7:0] q;
		logic [7:0] b;
		int         ntok;
		cmd_buf.delete();
		ntok = $urandom_range(1, 6);
		if ($urandom_range(99) < 20) begin
			// raw noise
			repeat ($urandom_range(1, 8))
				put_ch(8'($urandom_range(255)));
		end else begin
			repeat (ntok) begin
				case ($urandom_range(4))
					0: repeat ($urandom_range(1, 5)) put_ch(word_byte());
					1, 4: begin
						if ($urandom_range(1))
							repeat ($urandom_range(0, 2)) put_ch(word_byte());
						q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
						put_ch(q);
						repeat ($urandom_range(0, 5)) begin
							if ($urandom_range(5) == 0) begin
								put_ch(CH_BSLASH);
								put_ch(q);
							end else begin
								do
									b = 8'($urandom_range(255));
								while (b == q || b == CH_BSLASH);
								put_ch(b);
							end
						end
						if ($urandom_range(9) != 0)
							put_ch(q);
					end
					2: begin
						case ($urandom_range(2))
							0: put_ch(CH_PIPE);
							1: put_ch(CH_AMP);
							default: put_ch(CH_SEMI);
						endcase
					end
					default: begin
						repeat ($urandom_range(1, 3)) begin
							case ($urandom_range(3))
								0: put_ch(CH_SPACE);
								1: put_ch(CH_TAB);
								2: put_ch(CH_LF);
								default: put_ch(CH_NUL);
							endcase
						end
					end
				endcase
			end
		end
		foreach (cmd_buf[i])
			push_byte(cmd_buf[i], i == cmd_buf.size() - 1, ph);
	endtask

	task automatic push_text(input string s, input logic fin_at_end);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], fin_at_end && i == s.len() - 1, PH_DIRECTED);
	endtask

	task automatic fill_phase(input phase_t ph);
		int target;
		target = pending_bytes.size() + PHASE_BYTES;
		while (pending_bytes.size() < target)
			add_command(ph);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				lex_byte(bus_byte.ch, bus_byte.fin);
				n_bytes++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() != 0 &&
						$urandom_range(99) >= (pending_bytes[0].ph == PH_SRC_IDLE ? 69 :
						pending_bytes[0].ph == PH_BOTH_IDLE ? 25 : 0)) begin
					bus_byte = pending_bytes.pop_front();
					s_tvalid  <= 1'b1;
					s_tdata   <= bus_byte.ch;
					s_tlast   <= bus_byte.fin;
					cur_phase <= bus_byte.ph;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		token_rec_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_recs++;
				if (expected_recs.size() == 0) begin
					$error("unexpected record: tdata %h tlast %b", m_tdata, m_tlast);
					err_cnt++;
				end else begin
					want = expected_recs.pop_front();
					if (m_tdata[2:0] != want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, m_tdata[2:0]);
						err_cnt++;
					end
					if (m_tdata[10:3] != want.content) begin
						$error("content_byte: expected %h, got %h", want.content,
							m_tdata[10:3]);
						err_cnt++;
					end
					if (m_tdata[23:11] != want.first_pos) begin
						$error("first_pos: expected %0d, got %0d", want.first_pos,
							m_tdata[23:11]);
						err_cnt++;
					end
					if (m_tdata[36:24] != want.after_pos) begin
						$error("after_pos: expected %0d, got %0d", want.after_pos,
							m_tdata[36:24]);
						err_cnt++;
					end
					if (m_tdata[37] != want.quote_open) begin
						$error("quote_open: expected %b, got %b", want.quote_open,
							m_tdata[37]);
						err_cnt++;
					end
					if (m_tdata[39:38] != 2'b00) begin
						$error("pad: expected 0, got %0d", m_tdata[39:38]);
						err_cnt++;
					end
					if (m_tlast != want.last) begin
						$error("last_record: expected %b, got %b", want.last, m_tlast);
						err_cnt++;
					end
				end
			end
			// one long hold-off so the record queue fills and the input stalls
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (cur_phase == PH_BACKPRESSURE && !held_once) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(99) >= (cur_phase == PH_SNK_STALL ? 69 :
					cur_phase == PH_BOTH_IDLE ? 25 : 0);
			end
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				stuck = 0;
			else
				stuck++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		next_pos   = 0;
		in_string  = 1'b0;
		open_quote = QUOTE_NONE;
		prev_ch    = 8'h00;
		tok_start  = 0;
		err_cnt    = 0;
		n_bytes    = 0;
		n_cmds     = 0;
		n_recs     = 0;
		hold_left  = 0;
		held_once  = 1'b0;

		// words, all operators, empty quotes, high byte, NUL as separator,
		// NUL and escaped quote inside quotes, trailing whitespace
		push_text("ab |c&;\t\"\"\n", 1'b0);
		push_byte(8'hFF, 1'b0, PH_DIRECTED);
		push_byte(CH_NUL, 1'b0, PH_DIRECTED);
		push_byte(CH_SQUOTE, 1'b0, PH_DIRECTED);
		push_byte(CH_NUL, 1'b0, PH_DIRECTED);
		push_text("\\''", 1'b0);
		push_text(" ", 1'b1);
		// quote after a backslash still opens; left open at end of input
		push_text("\\\"q", 1'b1);
		push_text("z", 1'b1);
		push_text("|", 1'b1);
		push_text(" ", 1'b1);

		fill_phase(PH_STEADY);
		fill_phase(PH_SRC_IDLE);
		fill_phase(PH_SNK_STALL);
		fill_phase(PH_BOTH_IDLE);
		fill_phase(PH_BACKPRESSURE);
		fill_phase(PH_STEADY);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || s_tvalid || expected_recs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Lexed %0d bytes in %0d commands, %0d token records checked;", n_bytes,
			n_cmds, n_recs);
		$display("idle and stall mixes, one long output hold-off, open quotes at the end.");
		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/scl_pkg.sv
design/shell_command_lexer_core.sv
tb/shell_command_lexer_core_tb.sv
